/* src/dqs_pkg.sv */
// Shared types and constants for the deque with search.
// Used by the channel interfaces, the storage cell and the top level.
`default_nettype none

package dqs_pkg;

   localparam int DATA_W = 32;
   localparam int POS_W  = 5;

   // request operation codes
   typedef enum logic [1:0] {
      OP_PUSH_REAR  = 2'd0,
      OP_PUSH_FRONT = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_SEARCH     = 2'd3
   } opcode_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // what every cell of the chain does in a cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_PUSH_REAR,
      CELL_PUSH_FRONT,
      CELL_POP
   } cell_op_type;

   // command broadcast from the controller to all cells
   typedef struct packed {
      cell_op_type op;
      logic        advance;
      logic        kill;
   } cell_cmd_type;

   // controller states
   typedef enum logic {
      S_IDLE,
      S_SEARCH
   } ctrl_state_type;

endpackage

`default_nettype wire

/* src/dqs_if.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on dqs_pkg for the payload types.
`default_nettype none

interface dqs_req_if;
   logic                                valid;
   logic                                ready;
   dqs_pkg::opcode_type                 opcode;
   logic signed [dqs_pkg::DATA_W-1:0]   operand_value;

   modport source (output valid, output opcode, output operand_value, input ready);
   modport sink   (input valid, input opcode, input operand_value, output ready);
endinterface

interface dqs_rsp_if;
   logic                                valid;
   logic                                ready;
   dqs_pkg::status_type                 status;
   logic signed [dqs_pkg::DATA_W-1:0]   popped_value;
   logic        [dqs_pkg::POS_W-1:0]    found_position;

   modport source (output valid, output status, output popped_value,
                   output found_position, input ready);
   modport sink   (input valid, input status, input popped_value,
                   input found_position, output ready);
endinterface

`default_nettype wire

/* src/dqs_cell.sv */
// One storage cell of the deque chain: holds one entry and one search probe.
// Depends on dqs_pkg for the command struct.
`default_nettype none

module dqs_cell (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire dqs_pkg::cell_cmd_type              cmd,
   input  wire logic                               at_rear,
   input  wire logic signed [dqs_pkg::DATA_W-1:0]  operand,
   input  wire logic signed [dqs_pkg::DATA_W-1:0]  left_value,
   input  wire logic signed [dqs_pkg::DATA_W-1:0]  right_value,
   input  wire logic signed [dqs_pkg::DATA_W-1:0]  left_key,
   input  wire logic                               left_probe,
   output logic signed [dqs_pkg::DATA_W-1:0]       value,
   output logic signed [dqs_pkg::DATA_W-1:0]       key,
   output logic                                    probe,
   output logic                                    hit
);
   import dqs_pkg::*;

   logic signed [DATA_W-1:0] value_ff, value_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic                     probe_ff, probe_in;

   // entry movement: load at rear, shift toward rear, shift toward front
   always_comb begin
      case (cmd.op)
         CELL_PUSH_REAR:  value_in = at_rear ? operand : value_ff;
         CELL_PUSH_FRONT: value_in = left_value;
         CELL_POP:        value_in = right_value;
         default:         value_in = value_ff;
      endcase
   end

   // search probe and key walk one cell per step
   always_comb begin
      key_in   = cmd.advance ? left_key : key_ff;
      probe_in = cmd.advance ? left_probe : probe_ff;
      if (cmd.kill) begin
         probe_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      key_ff   <= key_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= 1'b0;
      end else begin
         probe_ff <= probe_in;
      end
   end

   assign value = value_ff;
   assign key   = key_ff;
   assign probe = probe_ff;
   assign hit   = probe_ff && (value_ff == key_ff);

endmodule

`default_nettype wire

/* src/deque_with_search_core.sv */
// Top level of the deque with search: controller, response register and cell chain.
// Depends on dqs_pkg, dqs_req_if / dqs_rsp_if and dqs_cell.
//
// Usage:
//   Requests arrive on req_if (opcode, operand_value); each gives exactly one
//   response on rsp_if (status, popped_value, found_position). Both channels
//   transfer when valid and ready are high at a rising clock edge.
//   Entries sit in a chain of CAPACITY cells, cell 0 being the front. Push
//   front and pop front shift the whole chain by one cell; push rear loads
//   the cell just behind the last entry.
//   Push and pop: the response is valid the cycle after the transfer, and a new
//   request can follow every cycle while the response register is free or being drained.
//   Search: the key travels down the chain one cell per cycle while the
//   response register is free or being drained. An empty deque answers at once.
//   Requests are not taken during a search.
//   Reset (synchronous, active high) empties the deque and drops any
//   pending response; stored values are not cleared.
//   When the receiver stalls, the response is held in its output register;
//   a new request is taken only once that register is free or being drained,
//   and a finished search waits in place until it can be written.
`default_nettype none

module deque_with_search_core #(
   parameter int CAPACITY = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dqs_req_if.sink    req_if,
   dqs_rsp_if.source  rsp_if
);
   import dqs_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   // controller state
   ctrl_state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  step_ff, step_in;

   // response register
   logic                     rsp_valid_ff;
   status_type               rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_popped_ff, rsp_popped_in;
   logic [POS_W-1:0]         rsp_pos_ff, rsp_pos_in;
   logic                     rsp_load;

   // chain wiring
   cell_cmd_type             cmd;
   logic                     inject;
   logic signed [DATA_W-1:0] cell_value [CAPACITY];
   logic signed [DATA_W-1:0] cell_key   [CAPACITY];
   logic                     cell_probe [CAPACITY];
   logic [CAPACITY-1:0]      cell_hit;
   logic [CAPACITY-1:0]      at_rear;

   logic          slot_free;
   logic          accept;
   logic          full;
   logic          empty;
   logic          hit_any;
   logic          last_step;
   logic [CW-1:0] step_pos;

   assign slot_free    = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == S_IDLE) && slot_free;
   assign accept       = req_if.valid && req_if.ready;
   assign full         = (count_ff == CW'(CAPACITY));
   assign empty        = (count_ff == '0);
   assign hit_any      = |cell_hit;
   assign step_pos     = step_ff + CW'(1);
   assign last_step    = (step_pos == count_ff);

   // next state, cell commands and response
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      cmd.op        = CELL_HOLD;
      cmd.advance   = 1'b0;
      cmd.kill      = 1'b0;
      inject        = 1'b0;
      rsp_load      = 1'b0;
      rsp_status_in = ST_OK;
      rsp_popped_in = '0;
      rsp_pos_in    = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_if.opcode)
                  OP_PUSH_REAR: begin
                     rsp_load = 1'b1;
                     if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        cmd.op   = CELL_PUSH_REAR;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_PUSH_FRONT: begin
                     rsp_load = 1'b1;
                     if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        cmd.op   = CELL_PUSH_FRONT;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_POP_FRONT: begin
                     rsp_load = 1'b1;
                     if (empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        cmd.op        = CELL_POP;
                        rsp_popped_in = cell_value[0];
                        count_in      = count_ff - CW'(1);
                     end
                  end
                  default: begin
                     if (empty) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = ST_NOT_FOUND;
                     end else begin
                        inject      = 1'b1;
                        cmd.advance = 1'b1;
                        step_in     = '0;
                        state_in    = S_SEARCH;
                     end
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (slot_free) begin
               if (hit_any) begin
                  rsp_load   = 1'b1;
                  rsp_pos_in = POS_W'(step_pos);
                  cmd.kill   = 1'b1;
                  state_in   = S_IDLE;
               end else if (last_step) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = ST_NOT_FOUND;
                  cmd.kill      = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  step_in     = step_pos;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         step_ff  <= step_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_popped_ff <= rsp_popped_in;
         rsp_pos_ff    <= rsp_pos_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = rsp_status_ff;
   assign rsp_if.popped_value   = rsp_popped_ff;
   assign rsp_if.found_position = rsp_pos_ff;

   // chain of cells, front at index 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_value;
      logic signed [DATA_W-1:0] right_value;
      logic signed [DATA_W-1:0] left_key;
      logic                     left_probe;

      assign at_rear[i] = (count_ff == CW'(i));

      if (i == 0) begin : g_front
         assign left_value = req_if.operand_value;
         assign left_key   = req_if.operand_value;
         assign left_probe = inject;
      end else begin : g_inner
         assign left_value = cell_value[i-1];
         assign left_key   = cell_key[i-1];
         assign left_probe = cell_probe[i-1];
      end

      if (i == CAPACITY - 1) begin : g_rear
         assign right_value = cell_value[i];
      end else begin : g_mid
         assign right_value = cell_value[i+1];
      end

      dqs_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .at_rear     (at_rear[i]),
         .operand     (req_if.operand_value),
         .left_value  (left_value),
         .right_value (right_value),
         .left_key    (left_key),
         .left_probe  (left_probe),
         .value       (cell_value[i]),
         .key         (cell_key[i]),
         .probe       (cell_probe[i]),
         .hit         (cell_hit[i])
      );
   end

endmodule

`default_nettype wire
